FILE: sv/page_frame_allocator_oldest_victim_unit_defines.svh
// Assertion macros used by the checker.
`ifndef PAGE_FRAME_ALLOCATOR_OLDEST_VICTIM_UNIT_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_OLDEST_VICTIM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PFA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pfa assertion failed");

// Next-cycle implication, disabled in reset.
`define PFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pfa assertion failed");

`endif

FILE: sv/pfa_pkg.sv
package pfa_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int VA_PAGE_BITS = 12;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int AGE_W      = 32;
  localparam int PAGE_W     = 52;
  localparam int UPAGE_W    = 27;
  localparam int OWNER_W    = 64;
  localparam int FIDX_W     = 6;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 152;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic             scan_start;
    logic             age_start;
    logic [IDX_W-1:0] pick;
  } age_cmd_t;

  typedef struct packed {
    logic             done;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] oldest_idx;
  } age_stat_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [UPAGE_W-1:0] upage;
  } frame_rec_t;

endpackage

FILE: sv/pfa_age_engine.sv
module pfa_age_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfa_pkg::age_cmd_t                   cmd_i,
  input  logic [pfa_pkg::NUM_FRAMES-1:0]      used_i,
  output pfa_pkg::age_stat_t                  stat_o
);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_SCAN = 3'b010,
    E_AGE  = 3'b100
  } eng_state_e;

  localparam int IW = pfa_pkg::IDX_W;
  localparam int AW = pfa_pkg::AGE_W;

  eng_state_e        state_q, state_d;
  logic [IW:0]       cnt_q, cnt_d;
  logic              rd_v_q;
  logic [IW-1:0]     rd_a_q;
  logic [AW-1:0]     rdata_q;
  logic              found_q, found_d;
  logic [IW-1:0]     free_q, free_d;
  logic [IW-1:0]     old_q, old_d;
  logic [AW-1:0]     best_q, best_d;
  logic [IW-1:0]     pick_q, pick_d;
  logic              done_q, done_d;

  logic              issue;
  logic              last;
  logic [IW-1:0]     ra;
  logic              we;
  logic [AW-1:0]     wd;

  logic [AW-1:0]     age_mem [pfa_pkg::NUM_FRAMES];

  always_comb begin
    issue = (state_q != E_IDLE) && (cnt_q < (IW+1)'(pfa_pkg::NUM_FRAMES));
    ra    = cnt_q[IW-1:0];
    last  = rd_v_q && (rd_a_q == IW'(pfa_pkg::NUM_FRAMES - 1));
    we    = (state_q == E_AGE) && rd_v_q && ((rd_a_q == pick_q) || used_i[rd_a_q]);
    if (rd_a_q == pick_q) begin
      wd = AW'(2);
    end else if (rdata_q == '1) begin
      wd = rdata_q;
    end else begin
      wd = rdata_q + AW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = issue ? cnt_q + (IW+1)'(1) : cnt_q;
    found_d = found_q;
    free_d  = free_q;
    old_d   = old_q;
    best_d  = best_q;
    pick_d  = pick_q;
    done_d  = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (cmd_i.scan_start) begin
          state_d = E_SCAN;
          cnt_d   = '0;
          found_d = 1'b0;
          free_d  = '0;
          old_d   = '0;
          best_d  = '0;
        end else if (cmd_i.age_start) begin
          state_d = E_AGE;
          cnt_d   = '0;
          pick_d  = cmd_i.pick;
        end
      end
      E_SCAN: begin
        if (rd_v_q) begin
          if (!used_i[rd_a_q] && !found_q) begin
            found_d = 1'b1;
            free_d  = rd_a_q;
          end
          if (rdata_q > best_q) begin
            best_d = rdata_q;
            old_d  = rd_a_q;
          end
        end
        if (last) begin
          state_d = E_IDLE;
          done_d  = 1'b1;
        end
      end
      E_AGE: begin
        if (last) begin
          state_d = E_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      rd_a_q  <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= issue;
      rd_a_q  <= ra;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_q <= free_d;
    old_q  <= old_d;
    best_q <= best_d;
    pick_q <= pick_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      age_mem[rd_a_q] <= wd;
    end
    if (issue) begin
      rdata_q <= age_mem[ra];
    end
  end

  assign stat_o.done       = done_q;
  assign stat_o.free_found = found_q;
  assign stat_o.free_idx   = free_q;
  assign stat_o.oldest_idx = old_q;

endmodule

FILE: sv/page_frame_allocator_oldest_victim_unit.sv
// Free: the input beat clears the used bit of an in-range index and goes to S_DONE, which loads the result beat.
// Allocate: the result beat is loaded after the states S_SCAN, S_VREAD, S_AGE and S_DONE,
// with one search pass and one aging pass through the single read port of the age memory.
// One request in flight at a time.
// Input ready returns once the result is loaded, so a waiting result blocks only the next one.
// Reset clears every used bit, the pool base and the handshake state; memories are not cleared.
module page_frame_allocator_oldest_victim_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // frame_index, user_page, owner_root, zero pad
  input  logic [pfa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // granted_index, granted_page, victim_user_page, victim_owner, zero pad
  output logic [pfa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // evicted
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfa_pkg::PAGE_W-1:0]         cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_VREAD = 5'b00100,
    S_AGE   = 5'b01000,
    S_DONE  = 5'b10000
  } top_state_e;

  localparam int IW = pfa_pkg::IDX_W;

  top_state_e                       state_q, state_d;
  logic [pfa_pkg::NUM_FRAMES-1:0]   used_q, used_d;
  logic [pfa_pkg::PAGE_W-1:0]       base_q;
  logic                             cmd_q;
  pfa_pkg::frame_rec_t              req_q;
  logic [IW-1:0]                    pick_q, pick_d;
  logic                             evict_q, evict_d;

  logic                             out_v_q;
  logic [pfa_pkg::FIDX_W-1:0]       out_idx_q;
  logic [pfa_pkg::PAGE_W-1:0]       out_page_q;
  logic                             out_ev_q;
  pfa_pkg::frame_rec_t              out_vic_q;

  pfa_pkg::frame_rec_t              pay_mem [pfa_pkg::NUM_FRAMES];
  pfa_pkg::frame_rec_t              pay_rd_q;
  logic                             pay_re;
  logic                             pay_we;

  pfa_pkg::age_cmd_t                eng_cmd;
  pfa_pkg::age_stat_t               eng_stat;

  logic                             in_beat;
  logic                             out_load;
  logic [pfa_pkg::FIDX_W-1:0]       in_fidx;

  pfa_age_engine u_age (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (eng_cmd),
    .used_i (used_q),
    .stat_o (eng_stat)
  );

  assign in_fidx       = s_axis_tdata[pfa_pkg::FIDX_W-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_v_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d            = state_q;
    used_d             = used_q;
    pick_d             = pick_q;
    evict_d            = evict_q;
    pay_re             = 1'b0;
    pay_we             = 1'b0;
    eng_cmd.scan_start = 1'b0;
    eng_cmd.age_start  = 1'b0;
    eng_cmd.pick       = pick_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == pfa_pkg::CMD_FREE) begin
            if ({1'b0, in_fidx} < (pfa_pkg::FIDX_W+1)'(pfa_pkg::NUM_FRAMES)) begin
              used_d[IW'(in_fidx)] = 1'b0;
            end
            state_d = S_DONE;
          end else begin
            eng_cmd.scan_start = 1'b1;
            state_d            = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (eng_stat.done) begin
          pick_d  = eng_stat.free_found ? eng_stat.free_idx : eng_stat.oldest_idx;
          evict_d = !eng_stat.free_found;
          state_d = S_VREAD;
        end
      end
      S_VREAD: begin
        pay_re            = 1'b1;
        pay_we            = 1'b1;
        used_d[pick_q]    = 1'b1;
        eng_cmd.age_start = 1'b1;
        state_d           = S_AGE;
      end
      S_AGE: begin
        if (eng_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      base_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q  <= pick_d;
    evict_q <= evict_d;
    if (in_beat) begin
      cmd_q       <= s_axis_tuser;
      req_q.upage <= s_axis_tdata[pfa_pkg::FIDX_W +: pfa_pkg::UPAGE_W];
      req_q.owner <= s_axis_tdata[pfa_pkg::FIDX_W + pfa_pkg::UPAGE_W +: pfa_pkg::OWNER_W];
    end
    if (out_load) begin
      if (cmd_q == pfa_pkg::CMD_FREE) begin
        out_idx_q  <= '0;
        out_page_q <= '0;
        out_ev_q   <= 1'b0;
        out_vic_q  <= '0;
      end else begin
        out_idx_q  <= pfa_pkg::FIDX_W'(pick_q);
        out_page_q <= base_q + pfa_pkg::PAGE_W'(pick_q);
        out_ev_q   <= evict_q;
        out_vic_q  <= evict_q ? pay_rd_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pick_q] <= req_q;
    end
    if (pay_re) begin
      pay_rd_q <= pay_mem[pick_q];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tdata  = {3'b000, out_vic_q.owner, out_vic_q.upage, out_page_q, out_idx_q};

endmodule

FILE: sv/pfa_checker.sv
`include "page_frame_allocator_oldest_victim_unit_defines.svh"

module pfa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [pfa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic                               m_axis_tuser
);

  logic                            in_beat;
  logic                            out_stall;
  logic                            no_evict;
  logic [pfa_pkg::OUT_DATA_W:0]    out_beat;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign no_evict  = m_axis_tvalid && !m_axis_tuser;
  assign out_beat  = {m_axis_tuser, m_axis_tdata};

  // stalled result beat holds
  `PFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_beat))
  // one request in flight
  `PFA_ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, in_beat, !s_axis_tready)
  // victim fields are zero without eviction
  `PFA_ASSERT_SAME(a_victim_zero, clk_i, rst_ni, no_evict, m_axis_tdata[148:58] == '0)
  // offered result beat carries known bits
  `PFA_ASSERT_SAME(a_out_known, clk_i, rst_ni, m_axis_tvalid, !$isunknown(out_beat))

endmodule

bind page_frame_allocator_oldest_victim_unit pfa_checker u_pfa_checker (.*);
